[src/rtp_h264_fu_a_packetizer_top_defines.svh]
// ----------------------------------------------------------------------------
// RTP H.264 packetizer assertion macros
// Shared property forms for the packetizer checker.
// ----------------------------------------------------------------------------
`ifndef RTP_H264_FU_A_PACKETIZER_TOP_DEFINES_SVH
`define RTP_H264_FU_A_PACKETIZER_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define RTPFU_ASSERT_IMPLY(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("%m: check failed");

// next-cycle implication, off during reset
`define RTPFU_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("%m: check failed");

// next-cycle implication, checked through reset
`define RTPFU_ASSERT_NEXT_ALWAYS(label, clk, a, c) \
  label: assert property (@(posedge clk) (a) |=> (c)) \
    else $error("%m: check failed");

`endif

[src/rtpfu_pkg.sv]
// ----------------------------------------------------------------------------
// RTP H.264 packetizer package
// Shared types and protocol constants for the FU-A packetizer.
// ----------------------------------------------------------------------------
package rtpfu_pkg;

  localparam logic [7:0]  RTP_VERSION_BYTE = 8'h80;
  localparam logic [7:0]  FU_A_TYPE        = 8'd28;
  localparam logic [7:0]  NRI_MASK         = 8'hE0;
  localparam logic [7:0]  TYPE_MASK        = 8'h1F;
  localparam logic [7:0]  FU_START_BIT     = 8'h80;
  localparam logic [7:0]  FU_END_BIT       = 8'h40;

  localparam logic [6:0]  PAYLOAD_TYPE_RESET   = 7'd96;
  localparam logic [31:0] SSRC_RESET           = 32'h1234_5678;
  localparam logic [11:0] MAX_UNIT_SIZE_RESET  = 12'd1400;
  localparam logic [31:0] TIMESTAMP_STEP_RESET = 32'd3600;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [3:0] HDR_LAST_IDX = 4'd11;
  localparam logic [3:0] FU_IND_IDX   = 4'd12;
  localparam logic [3:0] FU_HDR_IDX   = 4'd13;
  localparam logic [3:0] FU_DATA_IDX  = 4'd14;

  typedef enum logic [1:0] {
    REG_PAYLOAD_TYPE   = 2'd0,
    REG_SSRC           = 2'd1,
    REG_MAX_UNIT_SIZE  = 2'd2,
    REG_TIMESTAMP_STEP = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [6:0]  payload_type;
    logic [31:0] sync_source_id;
    logic [11:0] max_unit_size;
    logic [31:0] timestamp_step;
  } cfg_t;

  typedef struct packed {
    logic        hdr;
    logic        fu;
    logic        marker;
    logic        last;
    logic [7:0]  data;
    logic [7:0]  fu_ind;
    logic [7:0]  fu_hdr;
    logic [15:0] seq;
    logic [31:0] ts;
  } q_entry_t;

endpackage

[src/rtpfu_front.sv]
// ----------------------------------------------------------------------------
// RTP H.264 packetizer front end
// Accepts NAL bytes, tracks unit and fragment state, queues packet commands.
// ----------------------------------------------------------------------------
module rtpfu_front import rtpfu_pkg::*; #(
  parameter int LENGTH_BITS = 20
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cfg_t                   cfg,
  input  logic                   accept,
  input  logic [7:0]             data_byte,
  input  logic                   unit_start,
  input  logic [LENGTH_BITS-1:0] unit_length,
  input  logic                   frame_end,
  output logic                   push,
  output q_entry_t               push_entry
);

  localparam int CMP_W = (LENGTH_BITS > 12) ? LENGTH_BITS : 12;

  logic [15:0]            sequence_number, sequence_number_next;
  logic [31:0]            rtp_timestamp, rtp_timestamp_next;
  logic [7:0]             unit_header, unit_header_next;
  logic [LENGTH_BITS-1:0] unit_remaining, unit_remaining_next;
  logic [11:0]            fragment_count, fragment_count_next;
  logic                   fragmenting, fragmenting_next;
  logic                   first_fragment, first_fragment_next;

  logic [LENGTH_BITS-1:0] len_eff;
  logic [11:0]            psize;
  logic                   last_frag;
  logic [11:0]            fc_load;

  assign len_eff   = (unit_length == '0) ? LENGTH_BITS'(1) : unit_length;
  assign psize     = (cfg.max_unit_size >= 12'd3) ? (cfg.max_unit_size - 12'd2) : 12'd1;
  assign last_frag = CMP_W'(unit_remaining) <= CMP_W'(psize);
  assign fc_load   = (fragment_count != 12'd0) ? fragment_count :
                     (last_frag ? 12'(CMP_W'(unit_remaining)) : psize);

  always_comb begin
    sequence_number_next = sequence_number;
    rtp_timestamp_next   = rtp_timestamp;
    unit_header_next     = unit_header;
    unit_remaining_next  = unit_remaining;
    fragment_count_next  = fragment_count;
    fragmenting_next     = fragmenting;
    first_fragment_next  = first_fragment;
    push                 = 1'b0;
    push_entry.hdr       = 1'b0;
    push_entry.fu        = 1'b0;
    push_entry.marker    = 1'b0;
    push_entry.last      = 1'b0;
    push_entry.data      = data_byte;
    push_entry.fu_ind    = (unit_header & NRI_MASK) | FU_A_TYPE;
    push_entry.fu_hdr    = (unit_header & TYPE_MASK) |
                           (first_fragment ? FU_START_BIT :
                            (last_frag ? FU_END_BIT : 8'h00));
    push_entry.seq       = sequence_number;
    push_entry.ts        = rtp_timestamp;
    if (accept) begin
      if (unit_start) begin
        unit_header_next    = data_byte;
        unit_remaining_next = len_eff - LENGTH_BITS'(1);
        fragmenting_next    = CMP_W'(len_eff) >= CMP_W'(cfg.max_unit_size);
        first_fragment_next = fragmenting_next;
        fragment_count_next = 12'd0;
        if (!fragmenting_next) begin
          push                 = 1'b1;
          push_entry.hdr       = 1'b1;
          push_entry.marker    = 1'b1;
          push_entry.last      = (len_eff == LENGTH_BITS'(1));
          sequence_number_next = sequence_number + 16'd1;
        end
      end else if (unit_remaining != '0) begin
        unit_remaining_next = unit_remaining - LENGTH_BITS'(1);
        push                = 1'b1;
        if (!fragmenting) begin
          push_entry.last = (unit_remaining == LENGTH_BITS'(1));
        end else begin
          if (fragment_count == 12'd0) begin
            push_entry.hdr       = 1'b1;
            push_entry.fu        = 1'b1;
            push_entry.marker    = last_frag;
            first_fragment_next  = 1'b0;
            sequence_number_next = sequence_number + 16'd1;
          end
          fragment_count_next = fc_load - 12'd1;
          push_entry.last     = (fc_load == 12'd1);
        end
      end
      if (frame_end) begin
        rtp_timestamp_next = rtp_timestamp + cfg.timestamp_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sequence_number <= '0;
      rtp_timestamp   <= '0;
      unit_header     <= '0;
      unit_remaining  <= '0;
      fragment_count  <= '0;
      fragmenting     <= 1'b0;
      first_fragment  <= 1'b0;
    end else begin
      sequence_number <= sequence_number_next;
      rtp_timestamp   <= rtp_timestamp_next;
      unit_header     <= unit_header_next;
      unit_remaining  <= unit_remaining_next;
      fragment_count  <= fragment_count_next;
      fragmenting     <= fragmenting_next;
      first_fragment  <= first_fragment_next;
    end
  end

endmodule

[src/rtpfu_queue.sv]
// ----------------------------------------------------------------------------
// RTP H.264 packetizer command queue
// Short FIFO of packet commands between front end and byte emitter.
// ----------------------------------------------------------------------------
module rtpfu_queue import rtpfu_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  q_entry_t push_entry,
  output logic     full,
  input  logic     pop,
  output q_entry_t head,
  output logic     empty
);

  q_entry_t            entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     count;

  assign full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

[src/rtpfu_back.sv]
// ----------------------------------------------------------------------------
// RTP H.264 packetizer byte emitter
// Expands queued commands into RTP header, FU bytes and payload bytes.
// ----------------------------------------------------------------------------
module rtpfu_back import rtpfu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  q_entry_t   head,
  input  logic       empty,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       packet_start,
  output logic       packet_end
);

  logic [3:0] idx;
  logic       load;
  logic       is_payload;
  logic [7:0] byte_sel;

  assign load       = !empty && (!out_valid || out_ready);
  assign is_payload = !head.hdr ||
                      (!head.fu && (idx == FU_IND_IDX)) ||
                      (head.fu && (idx == FU_DATA_IDX));
  assign pop        = load && is_payload;

  always_comb begin
    byte_sel = head.data;
    if (!is_payload) begin
      case (idx)
        4'd0:        byte_sel = RTP_VERSION_BYTE;
        4'd1:        byte_sel = {head.marker, cfg.payload_type};
        4'd2:        byte_sel = head.seq[15:8];
        4'd3:        byte_sel = head.seq[7:0];
        4'd4:        byte_sel = head.ts[31:24];
        4'd5:        byte_sel = head.ts[23:16];
        4'd6:        byte_sel = head.ts[15:8];
        4'd7:        byte_sel = head.ts[7:0];
        4'd8:        byte_sel = cfg.sync_source_id[31:24];
        4'd9:        byte_sel = cfg.sync_source_id[23:16];
        4'd10:       byte_sel = cfg.sync_source_id[15:8];
        HDR_LAST_IDX: byte_sel = cfg.sync_source_id[7:0];
        FU_IND_IDX:  byte_sel = head.fu_ind;
        FU_HDR_IDX:  byte_sel = head.fu_hdr;
        default:     byte_sel = head.data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= is_payload ? 4'd0 : idx + 4'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte     <= byte_sel;
      packet_start <= head.hdr && (idx == 4'd0);
      packet_end   <= is_payload && head.last;
    end
  end

endmodule

[src/rtp_h264_fu_a_packetizer_top.sv]
// ----------------------------------------------------------------------------
// RTP H.264 FU-A packetizer
// Wraps NAL unit bytes into single-NAL or FU-A fragmented RTP packets.
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  in       in_valid / in_ready    data_byte, unit_start, unit_length, frame_end
//  out      out_valid / out_ready  out_byte, packet_start, packet_end
//  cfg      cfg_write              cfg_index, cfg_data
//
//  Every header and payload byte is one output transfer; a packet adds 12 header
//  bytes, 14 for an FU-A fragment. The output byte rate sets throughput.
//  A 4-entry command queue lets input bytes enter at one per cycle while
//  headers go out; in_ready drops only when that queue is full.
//  Reset is synchronous; config registers return to their defaults.
// ----------------------------------------------------------------------------
module rtp_h264_fu_a_packetizer_top import rtpfu_pkg::*; #(
  parameter int LENGTH_BITS = 20
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             data_byte,
  input  logic                   unit_start,
  input  logic [LENGTH_BITS-1:0] unit_length,
  input  logic                   frame_end,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             out_byte,
  output logic                   packet_start,
  output logic                   packet_end,
  input  logic                   cfg_write,
  input  logic [1:0]             cfg_index,
  input  logic [31:0]            cfg_data
);

  cfg_t     cfg;
  logic     accept;
  logic     push;
  q_entry_t push_entry;
  logic     full;
  logic     pop;
  logic     empty;
  q_entry_t head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.payload_type   <= PAYLOAD_TYPE_RESET;
      cfg.sync_source_id <= SSRC_RESET;
      cfg.max_unit_size  <= MAX_UNIT_SIZE_RESET;
      cfg.timestamp_step <= TIMESTAMP_STEP_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PAYLOAD_TYPE:   cfg.payload_type   <= cfg_data[6:0];
        REG_SSRC:           cfg.sync_source_id <= cfg_data;
        REG_MAX_UNIT_SIZE:  cfg.max_unit_size  <= cfg_data[11:0];
        REG_TIMESTAMP_STEP: cfg.timestamp_step <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  rtpfu_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .accept     (accept),
    .data_byte  (data_byte),
    .unit_start (unit_start),
    .unit_length(unit_length),
    .frame_end  (frame_end),
    .push       (push),
    .push_entry (push_entry)
  );

  rtpfu_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  rtpfu_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .head        (head),
    .empty       (empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .packet_start(packet_start),
    .packet_end  (packet_end)
  );

endmodule

[src/rtpfu_checker.sv]
// ----------------------------------------------------------------------------
// RTP H.264 packetizer port checker
// Watches the packetizer ports for output framing and stall behavior.
// ----------------------------------------------------------------------------
`include "rtp_h264_fu_a_packetizer_top_defines.svh"

module rtpfu_checker import rtpfu_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       packet_start,
  input logic       packet_end
);

  `RTPFU_ASSERT_NEXT_ALWAYS(a_idle_after_reset, clk, rst, !out_valid)
  `RTPFU_ASSERT_NEXT(a_stall_holds, clk, rst, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(packet_start) && $stable(packet_end))
  `RTPFU_ASSERT_IMPLY(a_start_is_version, clk, rst, out_valid && packet_start, out_byte == RTP_VERSION_BYTE)
  `RTPFU_ASSERT_IMPLY(a_start_not_end, clk, rst, out_valid, !(packet_start && packet_end))

endmodule

bind rtp_h264_fu_a_packetizer_top rtpfu_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_byte    (out_byte),
  .packet_start(packet_start),
  .packet_end  (packet_end)
);

[verif/rtpfu_tb_pkg.sv]
// ----------------------------------------------------------------------------
// RTP H.264 packetizer scoreboard
// Tracks sequence number, timestamp and FU-A fragmentation state from each
// accepted NAL byte. Queues the packet bytes the packetizer owes and compares
// every output transfer against the oldest one.
// ----------------------------------------------------------------------------
package rtpfu_tb_pkg;
  import rtpfu_pkg::*;

  localparam int NAL_LEN_W    = 20;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       sop;
    logic       eop;
  } pkt_byte_t;

  class rtp_packet_scoreboard;
    logic [6:0]           payload_type;
    logic [31:0]          ssrc;
    logic [11:0]          mtu;
    logic [31:0]          ts_step;
    logic [15:0]          seq_num;
    logic [31:0]          rtp_ts;
    logic [7:0]           nal_hdr;
    logic [NAL_LEN_W-1:0] bytes_left;
    logic [11:0]          frag_left;
    bit                   fragmenting;
    bit                   first_frag;
    pkt_byte_t            packet_bytes_due[$];
    int                   mismatches;
    int                   bytes_checked;
    int                   packets_checked;
    int                   units_started;
    int                   nal_bytes;

    function new();
      payload_type    = PAYLOAD_TYPE_RESET;
      ssrc            = SSRC_RESET;
      mtu             = MAX_UNIT_SIZE_RESET;
      ts_step         = TIMESTAMP_STEP_RESET;
      seq_num         = '0;
      rtp_ts          = '0;
      nal_hdr         = '0;
      bytes_left      = '0;
      frag_left       = '0;
      fragmenting     = 1'b0;
      first_frag      = 1'b0;
      mismatches      = 0;
      bytes_checked   = 0;
      packets_checked = 0;
      units_started   = 0;
      nal_bytes       = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [31:0] val);
      case (idx)
        REG_PAYLOAD_TYPE:   payload_type = val[6:0];
        REG_SSRC:           ssrc = val;
        REG_MAX_UNIT_SIZE:  mtu = val[11:0];
        REG_TIMESTAMP_STEP: ts_step = val;
        default: ;
      endcase
    endfunction

    function void queue_byte(logic [7:0] b, logic s, logic e);
      packet_bytes_due.push_back('{data: b, sop: s, eop: e});
    endfunction

    function void queue_header(logic marker);
      queue_byte(RTP_VERSION_BYTE, 1'b1, 1'b0);
      queue_byte({marker, payload_type}, 1'b0, 1'b0);
      queue_byte(seq_num[15:8], 1'b0, 1'b0);
      queue_byte(seq_num[7:0], 1'b0, 1'b0);
      queue_byte(rtp_ts[31:24], 1'b0, 1'b0);
      queue_byte(rtp_ts[23:16], 1'b0, 1'b0);
      queue_byte(rtp_ts[15:8], 1'b0, 1'b0);
      queue_byte(rtp_ts[7:0], 1'b0, 1'b0);
      queue_byte(ssrc[31:24], 1'b0, 1'b0);
      queue_byte(ssrc[23:16], 1'b0, 1'b0);
      queue_byte(ssrc[15:8], 1'b0, 1'b0);
      queue_byte(ssrc[7:0], 1'b0, 1'b0);
      seq_num = seq_num + 16'd1;
    endfunction

    function void accept_nal_byte(logic [7:0] b, logic s, logic [NAL_LEN_W-1:0] len,
                                  logic fe);
      logic [11:0]          frag_size;
      logic [NAL_LEN_W-1:0] n;
      logic [NAL_LEN_W-1:0] left;
      logic                 closing;
      logic [7:0]           fu_hdr;
      frag_size = (mtu >= 12'd3) ? mtu - 12'd2 : 12'd1;
      if (s) begin
        units_started++;
        nal_bytes++;
        n = len;
        if (n == '0)
          n = NAL_LEN_W'(1);
        nal_hdr     = b;
        bytes_left  = n - 1'b1;
        fragmenting = (n >= mtu);
        frag_left   = '0;
        first_frag  = fragmenting;
        if (!fragmenting) begin
          queue_header(1'b1);
          queue_byte(b, 1'b0, bytes_left == '0);
        end
      end else if (bytes_left != '0) begin
        nal_bytes++;
        left       = bytes_left;
        bytes_left = bytes_left - 1'b1;
        if (!fragmenting) begin
          queue_byte(b, 1'b0, bytes_left == '0);
        end else begin
          if (frag_left == '0) begin
            closing   = (left <= frag_size);
            frag_left = closing ? left[11:0] : frag_size;
            queue_header(closing);
            queue_byte((nal_hdr & NRI_MASK) | FU_A_TYPE, 1'b0, 1'b0);
            fu_hdr = nal_hdr & TYPE_MASK;
            if (first_frag)
              fu_hdr = fu_hdr | FU_START_BIT;
            else if (closing)
              fu_hdr = fu_hdr | FU_END_BIT;
            queue_byte(fu_hdr, 1'b0, 1'b0);
            first_frag = 1'b0;
          end
          frag_left = frag_left - 12'd1;
          queue_byte(b, 1'b0, frag_left == '0);
        end
      end
      if (fe)
        rtp_ts = rtp_ts + ts_step;
    endfunction

    function void report_mismatch(string msg);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("MISMATCH %s", msg);
    endfunction

    function void check_packet_byte(logic [7:0] b, logic s, logic e);
      pkt_byte_t want;
      bytes_checked++;
      if (s)
        packets_checked++;
      if (packet_bytes_due.size() == 0) begin
        report_mismatch($sformatf("output %0d: nothing expected, got %02h sop %0b eop %0b",
                                  bytes_checked, b, s, e));
        return;
      end
      want = packet_bytes_due.pop_front();
      if (b !== want.data || s !== want.sop || e !== want.eop)
        report_mismatch($sformatf(
          "output %0d: expected %02h sop %0b eop %0b, got %02h sop %0b eop %0b",
          bytes_checked, want.data, want.sop, want.eop, b, s, e));
    endfunction
  endclass

endpackage

[verif/tb.sv]
// ----------------------------------------------------------------------------
// RTP H.264 FU-A packetizer testbench
// Streams NAL units byte by byte, with directed corner cases followed by
// random units, cut-short units and stray bytes under several config
// settings and flow-control patterns. Every packet byte is checked in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rtpfu_pkg::*;
  import rtpfu_tb_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 64;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic [7:0]           data_byte;
  logic                 unit_start;
  logic [NAL_LEN_W-1:0] unit_length;
  logic                 frame_end;
  logic                 out_valid;
  logic                 out_ready;
  logic [7:0]           out_byte;
  logic                 packet_start;
  logic                 packet_end;
  logic                 cfg_write;
  logic [1:0]           cfg_index;
  logic [31:0]          cfg_data;

  rtp_packet_scoreboard sb;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int stalled_cycles = 0;
  int mtu_now;

  rtp_h264_fu_a_packetizer_top #(.LENGTH_BITS(NAL_LEN_W)) DUT (.*);

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(negedge clk)
    out_ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        sb.accept_nal_byte(data_byte, unit_start, unit_length, frame_end);
      if (out_valid && out_ready)
        sb.check_packet_byte(out_byte, packet_start, packet_end);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      stalled_cycles = 0;
    else
      stalled_cycles = stalled_cycles + 1;
    if (stalled_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("rtp_h264_fu_a_packetizer_top verification failed");
      $finish;
    end
  end

  task automatic send_nal_byte(input logic [7:0] b, input logic s,
                               input logic [NAL_LEN_W-1:0] len, input logic fe);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    data_byte   <= b;
    unit_start  <= s;
    unit_length <= len;
    frame_end   <= fe;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_unit(input logic [NAL_LEN_W-1:0] len_field, input int count,
                           input bit fe_last);
    for (int i = 0; i < count; i++)
      send_nal_byte(8'($urandom), i == 0, (i == 0) ? len_field : NAL_LEN_W'($urandom),
                    fe_last && (i == count - 1));
  endtask

  // hold input idle until every owed byte is out, then let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.packet_bytes_due.size() != 0)
      @(posedge clk);
    @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_one(input cfg_reg_t idx, input logic [31:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    sb.write_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic program_regs(input logic [6:0] pt, input logic [31:0] ssrc,
                              input logic [11:0] mtu, input logic [31:0] step);
    write_one(REG_PAYLOAD_TYPE, {25'd0, pt});
    write_one(REG_SSRC, ssrc);
    write_one(REG_MAX_UNIT_SIZE, {20'd0, mtu});
    write_one(REG_TIMESTAMP_STEP, step);
    cfg_write <= 1'b0;
    mtu_now = int'(mtu);
  endtask

  task automatic run_random_phase(input int send_pct, input int stall, input int target);
    int stop_at;
    int op;
    int len;
    int cap;
    send_idle_pct = send_pct;
    stall_pct     = stall;
    stop_at       = sb.nal_bytes + target;
    cap           = (mtu_now >= 64) ? 40 : 3 * mtu_now;
    while (sb.nal_bytes < stop_at) begin
      op = $urandom_range(99);
      if (op < 80) begin
        len = $urandom_range(cap, 1);
        send_unit(NAL_LEN_W'(len), len, 1'($urandom_range(1)));
      end else if (op < 88) begin
        repeat ($urandom_range(3, 1))
          send_nal_byte(8'($urandom), 1'b0, NAL_LEN_W'($urandom),
                        1'($urandom_range(1)));
      end else if (op < 96) begin
        // drop the unit after a few bytes
        send_unit(NAL_LEN_W'($urandom), $urandom_range(4, 1), 1'b0);
      end else begin
        send_unit('0, 1, 1'($urandom_range(1)));
      end
    end
    len = $urandom_range(cap, 1);
    send_unit(NAL_LEN_W'(len), len, 1'b1);
    drain();
  endtask

  initial begin
    sb          = new();
    rst         = 1'b1;
    in_valid    = 1'b0;
    data_byte   = '0;
    unit_start  = 1'b0;
    unit_length = '0;
    frame_end   = 1'b0;
    cfg_write   = 1'b0;
    cfg_index   = REG_PAYLOAD_TYPE;
    cfg_data    = '0;
    mtu_now     = int'(MAX_UNIT_SIZE_RESET);
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_nal_byte(8'h00, 1'b1, 20'd1, 1'b0);
    send_nal_byte(8'hFF, 1'b1, '0, 1'b1);
    send_nal_byte(8'hA5, 1'b0, 20'hFFFFF, 1'b1);
    send_nal_byte(8'h41, 1'b1, 20'hFFFFF, 1'b0);
    send_nal_byte(8'h9A, 1'b0, '0, 1'b0);
    send_nal_byte(8'h65, 1'b1, 20'd2, 1'b0);
    send_nal_byte(8'h5A, 1'b0, '0, 1'b1);
    drain();
    program_regs(7'h7F, 32'hFFFF_FFFF, 12'd16, 32'hFFFF_FFFF);
    send_unit(20'd16, 16, 1'b1);
    drain();
    program_regs('0, '0, '0, '0);
    send_unit(20'd1, 1, 1'b1);
    send_unit(20'd3, 3, 1'b1);
    drain();

    program_regs(7'($urandom), $urandom, 12'd4095, $urandom);
    run_random_phase(0, 0, 35);
    program_regs(7'($urandom), $urandom, 12'd16, $urandom);
    run_random_phase(0, 0, 50);
    program_regs(7'($urandom), $urandom, 12'($urandom_range(24, 17)), 32'd0);
    run_random_phase(82, 0, 40);
    program_regs(7'($urandom), $urandom, 12'($urandom_range(40, 16)), $urandom);
    run_random_phase(0, 82, 40);
    program_regs(PAYLOAD_TYPE_RESET, SSRC_RESET, 12'($urandom_range(24, 16)),
                 TIMESTAMP_STEP_RESET);
    run_random_phase(25, 25, 50);

    $display("Streamed %0d NAL bytes in %0d units; checked %0d packets, %0d packet bytes.",
             sb.nal_bytes, sb.units_started, sb.packets_checked, sb.bytes_checked);
    $display("Mismatches: %0d, packet bytes still owed: %0d",
             sb.mismatches, sb.packet_bytes_due.size());
    if (sb.mismatches == 0 && sb.packet_bytes_due.size() == 0)
      $display("rtp_h264_fu_a_packetizer_top verification clean");
    else
      $display("rtp_h264_fu_a_packetizer_top verification failed");
    $finish;
  end

endmodule
